@@ hw/rtl/load_cell_serial_readout_unit_defines.svh @@
// Assertion macros shared by the load-cell readout checker.
`ifndef LOAD_CELL_SERIAL_READOUT_UNIT_DEFINES_SVH
`define LOAD_CELL_SERIAL_READOUT_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define LCSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and held off during reset.
`define LCSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lcsr_pkg.sv @@
// Types and constants shared by the load-cell serial readout modules.
package lcsr_pkg;

    localparam int RAW_W      = 32;
    localparam int COUNT_W    = 24;
    localparam int WEIGHT_W   = 18;
    localparam int HALF_W     = 10;
    localparam int SCALE_W    = 24;
    localparam int FRAC_W     = 24;
    localparam int BIAS_W     = 16;
    localparam int PROD_W     = RAW_W + SCALE_W;
    localparam int TDATA_W    = 48;
    localparam int TDATA_PAD  = TDATA_W - 1 - COUNT_W - WEIGHT_W;
    localparam int S_TDATA_W  = 8;
    localparam int QUEUE_AW   = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS        = 2'd3;

    localparam logic [HALF_W-1:0]  HALF_RESET  = 10'd5;
    localparam logic [COUNT_W-1:0] TARE_RESET  = 24'd8417865;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd156505;
    localparam logic [BIAS_W-1:0]  BIAS_RESET  = 16'd350;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } phase_t;

    // One tick's outcome as the sequencer leaves it in the queue.
    typedef struct packed {
        logic             clock_pin;
        logic             reading_valid;
        logic [RAW_W-1:0] raw;
    } rec_t;

    typedef struct packed {
        logic               clock_pin;
        logic               reading_valid;
        logic [COUNT_W-1:0] raw_count;
        logic               neg;
        logic [RAW_W-1:0]   mag;
    } diff_t;

    typedef struct packed {
        logic               clock_pin;
        logic               reading_valid;
        logic [COUNT_W-1:0] raw_count;
        logic               neg;
        logic [PROD_W-1:0]  prod;
    } prod_t;

endpackage

@@ hw/rtl/load_cell_serial_readout_unit.sv @@
// Top level of the load-cell serial readout unit.
// Each input item is one tick carrying the sampled converter data level, and each
// tick yields exactly one result item with the serial clock level to drive; on the
// tick that finishes a conversion the result also carries the flipped raw count and
// the weight. Items are taken one per clock cycle while the queue is not full, and
// results leave one per cycle while m_tready is high. An accepted item is written
// into a four-entry queue and then passes the tare-subtract and 32x24 multiply stages
// into the output register, which takes the rounding with bias and clamp. While
// results are held off, up to seven ticks are buffered before s_tready drops. A conversion
// spans one start tick plus 2 x SAMPLE_BITS + 1 half periods of half_period_ticks ticks
// each. Configuration is to be written only while idle; the block does not enforce it.
module load_cell_serial_readout_unit #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcsr_pkg::S_TDATA_W-1:0]      s_tdata,   // [0] data_pin
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcsr_pkg::TDATA_W-1:0]        m_tdata,   // [0] clock_pin, [24:1] raw_count,
                                                           // [42:25] weight
    output logic                                m_tuser,   // [0] reading_valid
    input  logic                                cfg_we,
    input  logic [lcsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcsr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [lcsr_pkg::HALF_W-1:0]    half_period_reg;
    logic [lcsr_pkg::COUNT_W-1:0]   tare_reg;
    logic [lcsr_pkg::SCALE_W-1:0]   scale_reg;
    logic [lcsr_pkg::BIAS_W-1:0]    bias_reg;

    logic            step;
    logic            full;
    logic            empty;
    logic            pop;
    lcsr_pkg::rec_t  front_rec;
    lcsr_pkg::rec_t  queue_rec;

    assign s_tready = !full;
    assign step     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= lcsr_pkg::HALF_RESET;
            tare_reg        <= lcsr_pkg::TARE_RESET;
            scale_reg       <= lcsr_pkg::SCALE_RESET;
            bias_reg        <= lcsr_pkg::BIAS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcsr_pkg::CFG_HALF_PERIOD: half_period_reg <= cfg_wdata[lcsr_pkg::HALF_W-1:0];
                lcsr_pkg::CFG_TARE:        tare_reg        <= cfg_wdata[lcsr_pkg::COUNT_W-1:0];
                lcsr_pkg::CFG_SCALE:       scale_reg       <= cfg_wdata[lcsr_pkg::SCALE_W-1:0];
                lcsr_pkg::CFG_BIAS:        bias_reg        <= cfg_wdata[lcsr_pkg::BIAS_W-1:0];
                default:                   half_period_reg <= half_period_reg;
            endcase
        end
    end

    lcsr_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_pin    (s_tdata[0]),
        .half_period (half_period_reg),
        .rec         (front_rec)
    );

    lcsr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step),
        .din   (front_rec),
        .full  (full),
        .pop   (pop),
        .dout  (queue_rec),
        .empty (empty)
    );

    lcsr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_rec      (queue_rec),
        .in_valid    (!empty),
        .pop         (pop),
        .tare_offset (tare_reg),
        .scale_q24   (scale_reg),
        .weight_bias (bias_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

@@ hw/rtl/lcsr_fifo.sv @@
// Short queue of tick records between the sequencer and the arithmetic pipeline.
module lcsr_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lcsr_pkg::rec_t din,
    output logic          full,
    input  logic          pop,
    output lcsr_pkg::rec_t dout,
    output logic          empty
);

    localparam int DEPTH = 1 << lcsr_pkg::QUEUE_AW;

    lcsr_pkg::rec_t                 entry_reg [DEPTH];
    logic [lcsr_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [lcsr_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [lcsr_pkg::QUEUE_AW:0]    count_reg;
    logic [lcsr_pkg::QUEUE_AW:0]    count_next;

    assign full  = (count_reg == (lcsr_pkg::QUEUE_AW + 1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ hw/rtl/lcsr_front.sv @@
// Serial clock sequencer: one step per accepted item, shifts in the converter word.
module lcsr_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          data_pin,
    input  logic [lcsr_pkg::HALF_W-1:0]   half_period,
    output lcsr_pkg::rec_t                rec
);

    localparam int CNT_W = $clog2(SAMPLE_BITS + 1);
    localparam logic [SAMPLE_BITS-1:0] SIGN_MASK = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    lcsr_pkg::phase_t               phase_reg;
    lcsr_pkg::phase_t               phase_next;
    logic [CNT_W-1:0]               bit_cnt_reg;
    logic [CNT_W-1:0]               bit_cnt_next;
    logic [lcsr_pkg::HALF_W-1:0]    tick_reg;
    logic [lcsr_pkg::HALF_W-1:0]    tick_next;
    logic [SAMPLE_BITS-1:0]         shift_reg;
    logic [SAMPLE_BITS-1:0]         shift_next;
    logic                           clk_level_reg;
    logic                           clk_level_next;

    logic [lcsr_pkg::HALF_W-1:0]    half_eff;
    logic [lcsr_pkg::HALF_W-1:0]    tick_inc;
    logic                           half_done;

    always_comb
    begin
        half_eff  = (half_period == '0) ? lcsr_pkg::HALF_W'(1) : half_period;
        tick_inc  = tick_reg + 1'b1;
        half_done = (tick_inc >= half_eff) || (tick_inc == '0);
    end

    always_comb
    begin
        phase_next         = phase_reg;
        bit_cnt_next       = bit_cnt_reg;
        tick_next          = tick_reg;
        shift_next         = shift_reg;
        clk_level_next     = clk_level_reg;
        rec.reading_valid  = 1'b0;
        rec.raw            = '0;
        case (phase_reg)
            lcsr_pkg::PH_HIGH:
            begin
                tick_next = half_done ? '0 : tick_inc;
                if (half_done)
                begin
                    clk_level_next = 1'b0;
                    if (bit_cnt_reg >= CNT_W'(SAMPLE_BITS))
                    begin
                        rec.reading_valid = 1'b1;
                        rec.raw           = lcsr_pkg::RAW_W'(shift_reg ^ SIGN_MASK);
                        phase_next        = lcsr_pkg::PH_WAIT;
                        bit_cnt_next      = '0;
                    end
                    else
                    begin
                        phase_next = lcsr_pkg::PH_LOW;
                    end
                end
            end
            lcsr_pkg::PH_LOW:
            begin
                tick_next = half_done ? '0 : tick_inc;
                if (half_done)
                begin
                    shift_next     = {shift_reg[SAMPLE_BITS-2:0], data_pin};
                    bit_cnt_next   = bit_cnt_reg + 1'b1;
                    clk_level_next = 1'b1;
                    phase_next     = lcsr_pkg::PH_HIGH;
                end
            end
            default:
            begin
                phase_next     = lcsr_pkg::PH_WAIT;
                clk_level_next = 1'b0;
                if (!data_pin)
                begin
                    clk_level_next = 1'b1;
                    phase_next     = lcsr_pkg::PH_HIGH;
                    tick_next      = '0;
                    bit_cnt_next   = '0;
                    shift_next     = '0;
                end
            end
        endcase
        rec.clock_pin = clk_level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lcsr_pkg::PH_WAIT;
            bit_cnt_reg   <= '0;
            tick_reg      <= '0;
            shift_reg     <= '0;
            clk_level_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            tick_reg      <= tick_next;
            shift_reg     <= shift_next;
            clk_level_reg <= clk_level_next;
        end
    end

endmodule

@@ hw/rtl/lcsr_back.sv @@
// Weight pipeline: tare subtract, scale multiply, round toward zero, bias and clamp.
module lcsr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lcsr_pkg::rec_t                  in_rec,
    input  logic                            in_valid,
    output logic                            pop,
    input  logic [lcsr_pkg::COUNT_W-1:0]    tare_offset,
    input  logic [lcsr_pkg::SCALE_W-1:0]    scale_q24,
    input  logic [lcsr_pkg::BIAS_W-1:0]     weight_bias,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcsr_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tuser
);

    localparam int RW = lcsr_pkg::RAW_W;
    localparam int WW = lcsr_pkg::WEIGHT_W;

    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              en1;
    logic              en2;
    logic              en3;

    lcsr_pkg::diff_t   s1_reg;
    lcsr_pkg::diff_t   s1_next;
    lcsr_pkg::prod_t   s2_reg;
    lcsr_pkg::prod_t   s2_next;
    logic [lcsr_pkg::TDATA_W-1:0] out_reg;
    logic [lcsr_pkg::TDATA_W-1:0] out_next;
    logic              user_reg;

    logic [RW:0]       diff;
    logic [RW-1:0]     quot;
    logic [RW:0]       signed_q;
    logic [RW+1:0]     biased;
    logic [WW-1:0]     weight;

    assign en3 = !v3_reg || m_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pop = in_valid && en1;

    assign m_tvalid = v3_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = user_reg;

    always_comb
    begin
        diff                 = {1'b0, in_rec.raw} - (RW + 1)'(tare_offset);
        s1_next.clock_pin     = in_rec.clock_pin;
        s1_next.reading_valid = in_rec.reading_valid;
        s1_next.raw_count     = in_rec.raw[lcsr_pkg::COUNT_W-1:0];
        s1_next.neg           = diff[RW];
        s1_next.mag           = diff[RW] ? RW'(-diff) : diff[RW-1:0];
    end

    always_comb
    begin
        s2_next.clock_pin     = s1_reg.clock_pin;
        s2_next.reading_valid = s1_reg.reading_valid;
        s2_next.raw_count     = s1_reg.raw_count;
        s2_next.neg           = s1_reg.neg;
        s2_next.prod          = lcsr_pkg::PROD_W'(s1_reg.mag)
                              * lcsr_pkg::PROD_W'(scale_q24);
    end

    always_comb
    begin
        quot     = s2_reg.prod[lcsr_pkg::PROD_W-1:lcsr_pkg::FRAC_W];
        signed_q = s2_reg.neg ? -{1'b0, quot} : {1'b0, quot};
        biased   = {signed_q[RW], signed_q} - (RW + 2)'(weight_bias);
        if (biased[RW+1:WW-1] != {(RW - WW + 3){biased[RW+1]}})
        begin
            weight = biased[RW+1] ? {1'b1, {(WW - 1){1'b0}}} : {1'b0, {(WW - 1){1'b1}}};
        end
        else
        begin
            weight = biased[WW-1:0];
        end
        if (!s2_reg.reading_valid)
        begin
            weight = '0;
        end
        out_next = {{lcsr_pkg::TDATA_PAD{1'b0}}, weight, s2_reg.raw_count,
                    s2_reg.clock_pin};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg <= s1_next;
        end
        if (en2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (en3 && v2_reg)
        begin
            out_reg  <= out_next;
            user_reg <= s2_reg.reading_valid;
        end
    end

endmodule

@@ hw/rtl/lcsr_checker.sv @@
// Port-level checker for the load-cell serial readout unit, bound to the top level.
`include "load_cell_serial_readout_unit_defines.svh"

module lcsr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lcsr_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                            m_tuser
);

    `LCSR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output item changed")
    `LCSR_ASSERT_NOW(a_idle_fields_zero, m_tvalid && !m_tuser, m_tdata[lcsr_pkg::TDATA_W-1:1] == '0, "non-reading item carries data")
    `LCSR_ASSERT_NOW(a_reading_clock_low, m_tvalid && m_tuser, !m_tdata[0], "reading reported with clock high")
    `LCSR_ASSERT_NEXT(a_no_double_reading, m_tvalid && m_tready && m_tuser, !(m_tvalid && m_tuser), "two readings in a row")

endmodule

bind load_cell_serial_readout_unit lcsr_checker u_lcsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/load_cell_serial_readout_unit_tb.sv @@
// Self-checking testbench for the load-cell serial readout unit, with its own readout predictor.
module load_cell_serial_readout_unit_tb;

    localparam int SAMPLE_BITS    = 24;
    localparam int HALF_CYCLE     = 6;
    localparam int IDLE_LIMIT     = 4000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_TICKS    = 40;
    localparam int PHASE_READINGS = 1;
    localparam int HOLD_OFF       = 300;
    localparam int LONG_TICKS     = 30;
    localparam int RAW_LSB        = 1;
    localparam int WEIGHT_LSB     = RAW_LSB + lcsr_pkg::COUNT_W;
    localparam int PAD_LSB        = WEIGHT_LSB + lcsr_pkg::WEIGHT_W;
    localparam logic [lcsr_pkg::COUNT_W-1:0] SIGN_FLIP = 24'h800000;
    localparam longint WEIGHT_MAX = 131071;
    localparam longint WEIGHT_MIN = -131072;

    typedef struct packed {
        logic                                 clock_pin;
        logic                                 reading_valid;
        logic [lcsr_pkg::COUNT_W-1:0]         raw_count;
        logic signed [lcsr_pkg::WEIGHT_W-1:0] weight;
    } tick_out_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [lcsr_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [lcsr_pkg::TDATA_W-1:0]    m_tdata;
    logic                            m_tuser;
    logic                            cfg_we    = 1'b0;
    logic [lcsr_pkg::CFG_IDX_W-1:0]  cfg_index = lcsr_pkg::CFG_HALF_PERIOD;
    logic [lcsr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [lcsr_pkg::HALF_W-1:0]  set_half  = lcsr_pkg::HALF_RESET;
    logic [lcsr_pkg::COUNT_W-1:0] set_tare  = lcsr_pkg::TARE_RESET;
    logic [lcsr_pkg::SCALE_W-1:0] set_scale = lcsr_pkg::SCALE_RESET;
    logic [lcsr_pkg::BIAS_W-1:0]  set_bias  = lcsr_pkg::BIAS_RESET;
    lcsr_pkg::phase_t             rd_phase  = lcsr_pkg::PH_WAIT;
    logic [4:0]                   rd_bits   = '0;
    logic [lcsr_pkg::HALF_W-1:0]  rd_ticks  = '0;
    logic [lcsr_pkg::COUNT_W-1:0] rd_word   = '0;
    logic                         rd_clock  = 1'b0;

    tick_out_t expected_ticks[$];
    int mismatches     = 0;
    int ticks_sent     = 0;
    int readings_done  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_burst    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    load_cell_serial_readout_unit #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #HALF_CYCLE clk = 1'b1;
        #HALF_CYCLE clk = 1'b0;
    end

    function automatic logic [lcsr_pkg::HALF_W-1:0] effective_half();
        return (set_half == '0) ? lcsr_pkg::HALF_W'(1) : set_half;
    endfunction

    function automatic bit half_elapsed();
        rd_ticks = rd_ticks + 1'b1;
        if (rd_ticks >= effective_half() || rd_ticks == '0)
        begin
            rd_ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit samples_next();
        logic [lcsr_pkg::HALF_W-1:0] nxt;
        nxt = rd_ticks + 1'b1;
        return rd_phase == lcsr_pkg::PH_LOW && (nxt >= effective_half() || nxt == '0);
    endfunction

    function automatic logic signed [lcsr_pkg::WEIGHT_W-1:0] scaled_weight(
        logic [lcsr_pkg::COUNT_W-1:0] raw);
        longint diff;
        longint prod;
        longint q;
        diff = longint'({40'd0, raw}) - longint'({40'd0, set_tare});
        prod = diff * longint'({40'd0, set_scale});
        q = (prod >= 0) ? (prod >>> lcsr_pkg::FRAC_W) : -((-prod) >>> lcsr_pkg::FRAC_W);
        q = q - longint'({48'd0, set_bias});
        if (q > WEIGHT_MAX)
            q = WEIGHT_MAX;
        if (q < WEIGHT_MIN)
            q = WEIGHT_MIN;
        return q[lcsr_pkg::WEIGHT_W-1:0];
    endfunction

    function automatic tick_out_t advance_readout(logic pin);
        tick_out_t r;
        r = '0;
        case (rd_phase)
            lcsr_pkg::PH_HIGH:
                if (half_elapsed())
                begin
                    rd_clock = 1'b0;
                    if (rd_bits >= SAMPLE_BITS)
                    begin
                        r.reading_valid = 1'b1;
                        r.raw_count     = rd_word ^ SIGN_FLIP;
                        r.weight        = scaled_weight(r.raw_count);
                        rd_phase        = lcsr_pkg::PH_WAIT;
                        rd_bits         = '0;
                    end
                    else
                        rd_phase = lcsr_pkg::PH_LOW;
                end
            lcsr_pkg::PH_LOW:
                if (half_elapsed())
                begin
                    rd_word  = {rd_word[lcsr_pkg::COUNT_W-2:0], pin};
                    rd_bits  = rd_bits + 1'b1;
                    rd_clock = 1'b1;
                    rd_phase = lcsr_pkg::PH_HIGH;
                end
            default:
            begin
                rd_phase = lcsr_pkg::PH_WAIT;
                rd_clock = 1'b0;
                if (!pin)
                begin
                    rd_clock = 1'b1;
                    rd_phase = lcsr_pkg::PH_HIGH;
                    rd_ticks = '0;
                    rd_bits  = '0;
                    rd_word  = '0;
                end
            end
        endcase
        r.clock_pin = rd_clock;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_tick(input logic pin, output bit reading);
        tick_out_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(lcsr_pkg::S_TDATA_W-1){1'b0}}, pin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = advance_readout(pin);
        expected_ticks.push_back(r);
        ticks_sent++;
        reading = r.reading_valid;
        if (reading)
            readings_done++;
    endtask

    // Sends one tick whose level starts a conversion, feeds the next bit of word, or fills between samples.
    task automatic send_word_tick(input logic [lcsr_pkg::COUNT_W-1:0] word, input bit noisy,
                                  output bit done);
        logic pin;
        if (rd_phase == lcsr_pkg::PH_WAIT)
            pin = 1'b0;
        else if (samples_next())
            pin = word[lcsr_pkg::COUNT_W - 1 - int'(rd_bits)];
        else
            pin = noisy ? 1'($urandom_range(1)) : 1'b1;
        send_tick(pin, done);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [lcsr_pkg::HALF_W-1:0] half,
                                 input logic [lcsr_pkg::COUNT_W-1:0] tare,
                                 input logic [lcsr_pkg::SCALE_W-1:0] scale,
                                 input logic [lcsr_pkg::BIAS_W-1:0] bias);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= lcsr_pkg::CFG_HALF_PERIOD;
        cfg_wdata <= lcsr_pkg::CFG_DATA_W'(half);
        @(posedge clk);
        cfg_index <= lcsr_pkg::CFG_TARE;
        cfg_wdata <= lcsr_pkg::CFG_DATA_W'(tare);
        @(posedge clk);
        cfg_index <= lcsr_pkg::CFG_SCALE;
        cfg_wdata <= lcsr_pkg::CFG_DATA_W'(scale);
        @(posedge clk);
        cfg_index <= lcsr_pkg::CFG_BIAS;
        cfg_wdata <= lcsr_pkg::CFG_DATA_W'(bias);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        set_half  = half;
        set_tare  = tare;
        set_scale = scale;
        set_bias  = bias;
    endtask

    // Rewrites only the half period, leaving the other registers as they are.
    task automatic load_half(input logic [lcsr_pkg::HALF_W-1:0] half);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= lcsr_pkg::CFG_HALF_PERIOD;
        cfg_wdata <= lcsr_pkg::CFG_DATA_W'(half);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        set_half = half;
    endtask

    task automatic load_random_settings();
        logic [lcsr_pkg::SCALE_W-1:0] scale;
        scale = ($urandom_range(3) == 0) ? lcsr_pkg::SCALE_W'($urandom)
                                         : lcsr_pkg::SCALE_W'($urandom_range(1 << 17));
        load_settings(lcsr_pkg::HALF_W'($urandom_range(2)), lcsr_pkg::COUNT_W'($urandom),
                      scale, lcsr_pkg::BIAS_W'($urandom));
    endtask

    // Finishes the conversion in progress, or starts one, taking the bits it samples from word.
    task automatic run_conversion(input logic [lcsr_pkg::COUNT_W-1:0] word, input int wait_ticks,
                                  input bit noisy);
        bit done;
        if (rd_phase == lcsr_pkg::PH_WAIT)
            repeat (wait_ticks) send_tick(1'b1, done);
        done = 1'b0;
        while (!done)
            send_word_tick(word, noisy, done);
    endtask

    task automatic send_noise(input int count);
        bit done;
        repeat (count) send_tick(1'($urandom_range(1)), done);
    endtask

    function automatic logic [lcsr_pkg::COUNT_W-1:0] pick_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return (set_tare + lcsr_pkg::COUNT_W'($urandom_range(2000))
                       - lcsr_pkg::COUNT_W'(1000)) ^ SIGN_FLIP;
            default: return lcsr_pkg::COUNT_W'($urandom);
        endcase
    endfunction

    task automatic test_reset_values();
        logic [lcsr_pkg::COUNT_W-1:0] word;
        bit done;
        word = lcsr_pkg::TARE_RESET ^ SIGN_FLIP;
        repeat (3) send_tick(1'b1, done);
        repeat (LONG_TICKS) send_word_tick(word, 1'b0, done);
        load_half(lcsr_pkg::HALF_W'(1));
        run_conversion(word, 0, 1'b1);
    endtask

    task automatic test_zero_half_period();
        load_settings('0, lcsr_pkg::TARE_RESET, lcsr_pkg::SCALE_RESET, lcsr_pkg::BIAS_RESET);
        run_conversion(lcsr_pkg::COUNT_W'($urandom), 2, 1'b1);
    endtask

    task automatic test_weight_saturation();
        load_settings(lcsr_pkg::HALF_W'(1), '0, '1, '0);
        run_conversion(24'h7FFFFF, 0, 1'b1);
        load_settings(lcsr_pkg::HALF_W'(1), '1, '1, '1);
        run_conversion(24'h800000, 0, 1'b1);
    endtask

    task automatic test_field_extremes();
        load_settings(lcsr_pkg::HALF_W'(1), 24'h800000, 24'h010000, '0);
        run_conversion(24'h000000, 1, 1'b1);
        run_conversion(24'hFFFFFF, 1, 1'b0);
    endtask

    task automatic test_longest_half_period();
        logic [lcsr_pkg::COUNT_W-1:0] word;
        bit done;
        word = lcsr_pkg::COUNT_W'($urandom);
        load_settings('1, lcsr_pkg::COUNT_W'($urandom),
                      lcsr_pkg::SCALE_W'($urandom_range(1 << 16)), lcsr_pkg::BIAS_W'($urandom));
        repeat (2) send_tick(1'b1, done);
        repeat (LONG_TICKS) send_word_tick(word, 1'b1, done);
        load_half(lcsr_pkg::HALF_W'(1));
        run_conversion(word, 0, 1'b1);
    endtask

    task automatic test_backpressure();
        load_settings(lcsr_pkg::HALF_W'(1), lcsr_pkg::TARE_RESET, lcsr_pkg::SCALE_RESET,
                      lcsr_pkg::BIAS_RESET);
        stall_burst = HOLD_OFF;
        run_conversion(pick_word(), 1, 1'b1);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int tick_goal;
        int reading_goal;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        load_random_settings();
        tick_goal    = ticks_sent + PHASE_TICKS;
        reading_goal = readings_done + PHASE_READINGS;
        while (ticks_sent < tick_goal || readings_done < reading_goal)
        begin
            if ($urandom_range(9) == 0)
                load_random_settings();
            if ($urandom_range(4) == 0)
                send_noise($urandom_range(1, 20));
            else
                run_conversion(pick_word(), $urandom_range(4), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(25, 49);
        run_random_phase(49, 25);
        run_random_phase(0, 0);
    endtask

    always @(posedge clk)
    begin
        if (stall_burst != 0)
        begin
            hold_left   = stall_burst;
            stall_burst = 0;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        tick_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_ticks.size() == 0)
                report_mismatch($sformatf("result item with none expected, tdata=%h", m_tdata));
            else
            begin
                want = expected_ticks.pop_front();
                if (m_tdata[0] !== want.clock_pin || m_tuser !== want.reading_valid
                    || m_tdata[RAW_LSB +: lcsr_pkg::COUNT_W] !== want.raw_count
                    || m_tdata[WEIGHT_LSB +: lcsr_pkg::WEIGHT_W] !== want.weight
                    || m_tdata[lcsr_pkg::TDATA_W-1:PAD_LSB] !== '0)
                    report_mismatch($sformatf(
                        "clk %b/%b valid %b/%b raw %h/%h weight %0d/%0d pad %h (got/exp)",
                        m_tdata[0], want.clock_pin, m_tuser, want.reading_valid,
                        m_tdata[RAW_LSB +: lcsr_pkg::COUNT_W], want.raw_count,
                        $signed(m_tdata[WEIGHT_LSB +: lcsr_pkg::WEIGHT_W]), want.weight,
                        m_tdata[lcsr_pkg::TDATA_W-1:PAD_LSB]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_zero_half_period();
        test_weight_saturation();
        test_field_extremes();
        test_longest_half_period();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
